// ----- rtl/core/plist_pkg.sv -----
// ----------------------------------------------------------------------------
// plist_pkg
// Shared codes and control types for the positional list engine.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int unsigned MODE_W     = 2;
    localparam int unsigned POSITION_W = 6;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned LENGTH_W   = 6;

    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the incoming request
        logic execute;  // perform the request and load the result register
    } ctrl_cmd_t;

endpackage

// ----- rtl/core/plist_if.sv -----
// ----------------------------------------------------------------------------
// plist_req_if / plist_rsp_if
// Valid/ready channels for list requests and list results.
// ----------------------------------------------------------------------------
interface plist_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [plist_pkg::MODE_W-1:0]         mode;
    logic [plist_pkg::POSITION_W-1:0]     position;
    logic signed [plist_pkg::DATA_W-1:0]  value;

    modport source (output valid, output mode, output position, output value, input ready);
    modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface plist_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 status;
    logic signed [plist_pkg::DATA_W-1:0]  element;
    logic [plist_pkg::LENGTH_W-1:0]       length;

    modport source (output valid, output status, output element, output length, input ready);
    modport sink   (input valid, input status, input element, input length, output ready);
endinterface

// ----- rtl/core/plist_ctrl.sv -----
// ----------------------------------------------------------------------------
// plist_ctrl
// Request sequencer: capture, execute, hand the item to the result register.
// ----------------------------------------------------------------------------
module plist_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output plist_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    // Result register can take a new item when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.load    = in_valid && in_ready;
    assign cmd.execute = (state_reg == S_EXEC) && slot_free;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_EXEC))
        else $error("accepted item did not move to execute");

    a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("executed item not presented as result");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !slot_free) |=> (state_reg == S_EXEC && out_valid_reg))
        else $error("execute left while result register was blocked");

endmodule

// ----- rtl/core/plist_dp.sv -----
// ----------------------------------------------------------------------------
// plist_dp
// Element row, length counter, request and result registers.
// ----------------------------------------------------------------------------
module plist_dp
#(
    parameter int unsigned CAPACITY = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  plist_pkg::ctrl_cmd_t                  cmd,
    input  logic [plist_pkg::MODE_W-1:0]          in_mode,
    input  logic [plist_pkg::POSITION_W-1:0]      in_position,
    input  logic signed [plist_pkg::DATA_W-1:0]   in_value,
    output logic                                  out_status,
    output logic signed [plist_pkg::DATA_W-1:0]   out_element,
    output logic [plist_pkg::LENGTH_W-1:0]        out_length
);

    localparam int unsigned LW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned CW = ((LW > plist_pkg::POSITION_W) ? LW : plist_pkg::POSITION_W) + 1;

    logic [plist_pkg::MODE_W-1:0]         req_mode_reg;
    logic [plist_pkg::POSITION_W-1:0]     req_pos_reg;
    logic signed [plist_pkg::DATA_W-1:0]  req_value_reg;

    logic [LW-1:0]                        len_reg;
    logic signed [plist_pkg::DATA_W-1:0]  row_reg  [CAPACITY];
    logic signed [plist_pkg::DATA_W-1:0]  row_next [CAPACITY];
    logic signed [plist_pkg::DATA_W-1:0]  below    [CAPACITY];
    logic signed [plist_pkg::DATA_W-1:0]  above    [CAPACITY];

    logic                                 status_reg;
    logic signed [plist_pkg::DATA_W-1:0]  element_reg;
    logic [plist_pkg::LENGTH_W-1:0]       length_reg;

    logic [CW-1:0]                        pos_w, len_w, pidx_w, len_next_w;
    logic                                 pos_nz, in_range, ins_ok, ok;
    logic                                 do_insert, do_delete;
    logic signed [plist_pkg::DATA_W-1:0]  rd_data, elem_next;

    // Capture request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_mode_reg  <= in_mode;
            req_pos_reg   <= in_position;
            req_value_reg <= in_value;
        end
    end

    assign pos_w    = CW'(req_pos_reg);
    assign len_w    = CW'(len_reg);
    assign pidx_w   = pos_w - CW'(1);
    assign pos_nz   = (req_pos_reg != '0);
    assign in_range = pos_nz && (pos_w <= len_w);
    assign ins_ok   = pos_nz && (pos_w <= len_w + CW'(1)) && (len_w < CW'(CAPACITY));
    assign rd_data  = row_reg[pidx_w[IW-1:0]];

    always_comb
    begin
        ok         = 1'b1;
        elem_next  = '0;
        len_next_w = len_w;
        do_insert  = 1'b0;
        do_delete  = 1'b0;
        unique case (req_mode_reg)
            plist_pkg::MODE_CLEAR:
            begin
                len_next_w = '0;
            end
            plist_pkg::MODE_GET:
            begin
                ok = in_range;
                if (in_range)
                begin
                    elem_next = rd_data;
                end
            end
            plist_pkg::MODE_INSERT:
            begin
                ok        = ins_ok;
                do_insert = ins_ok;
                if (ins_ok)
                begin
                    len_next_w = len_w + CW'(1);
                end
            end
            plist_pkg::MODE_DELETE:
            begin
                ok        = in_range;
                do_delete = in_range;
                if (in_range)
                begin
                    elem_next  = rd_data;
                    len_next_w = len_w - CW'(1);
                end
            end
            default:
            begin
                ok = 1'b1;
            end
        endcase
    end

    // Neighbor taps; entries past the length are don't-care
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_row
        if (i == 0)
        begin : g_first
            assign below[i] = row_reg[i];
        end
        else
        begin : g_mid
            assign below[i] = row_reg[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign above[i] = row_reg[i];
        end
        else
        begin : g_inner
            assign above[i] = row_reg[i+1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            row_next[i] = row_reg[i];
            if (do_insert)
            begin
                if (CW'(i) == pidx_w)
                begin
                    row_next[i] = req_value_reg;
                end
                else if (CW'(i) > pidx_w)
                begin
                    row_next[i] = below[i];
                end
            end
            else if (do_delete && (CW'(i) >= pidx_w))
            begin
                row_next[i] = above[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            row_reg     <= row_next;
            status_reg  <= !ok;
            element_reg <= elem_next;
            length_reg  <= len_next_w[plist_pkg::LENGTH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cmd.execute)
        begin
            len_reg <= len_next_w[LW-1:0];
        end
    end

    assign out_status  = status_reg;
    assign out_element = element_reg;
    assign out_length  = length_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(len_reg) <= CW'(CAPACITY))
        else $error("list length beyond capacity");

endmodule

// ----- rtl/core/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit elements with positional get/insert/delete.
// ----------------------------------------------------------------------------
// Each request item carries a mode (clear, get, insert, delete), a 1-based
// position and a value. One result item comes back per request with an error
// flag, the element read or removed (zero otherwise) and the list length after
// the request, modulo 64. Elements live in a row of CAPACITY registers that
// shift in parallel, so an insert or delete anywhere in the list is done in
// the execute step. Each item is captured in the request registers, then
// executed, loading the result register; the next request is taken the
// cycle after execute, while the previous result may still wait at the output.
// If the result register is still held by the sink, execute waits for it.
// Other than for clear, a position of zero or past the length (length+1 for
// insert), or an insert into a full list, errors and leaves the list intact.
// ----------------------------------------------------------------------------
module positional_list_engine
#(
    parameter int unsigned CAPACITY = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    plist_req_if.sink         req,
    plist_rsp_if.source       rsp
);

    plist_pkg::ctrl_cmd_t cmd;

    // Sequencer: accept, execute, present
    plist_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // Element row, length and result payload
    plist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_mode     (req.mode),
        .in_position (req.position),
        .in_value    (req.value),
        .out_status  (rsp.status),
        .out_element (rsp.element),
        .out_length  (rsp.length)
    );

endmodule
